/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a cause is followed by an effect on the next clock edge.
`define ASSERT_NEXT(label, clk, rst, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) else $error(msg);

`endif

/* rtl/pfr_pkg.sv */
// Shared constants, codes and command/status types of the page queue.
package pfr_pkg;

  localparam int DEPTH      = 64;
  localparam int PAGE_BITS  = 16;
  localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);
  localparam int SUM_BITS   = COUNT_BITS + 1;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_TAKE   = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic       start;
    logic       rd_en;
    logic       rd_head;
    logic       append;
    logic       take;
    logic       found;
    logic       advance;
    logic       shift_wr;
    logic       remove;
    logic       clear;
    logic       set_status;
    logic [1:0] status;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic scan_end;
    logic match;
  } stat_t;

  function automatic logic [ADDR_BITS-1:0] ptr_inc(input logic [ADDR_BITS-1:0] p);
    if (p == ADDR_BITS'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

endpackage

/* rtl/pfr_ctrl.sv */
// Sequencer of the page queue: steps each operation and owns the handshakes.
module pfr_ctrl
  import pfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  output logic       out_valid,
  input  logic       out_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_APPEND   = 4'd1;
  localparam logic [3:0] S_TAKE_RD  = 4'd2;
  localparam logic [3:0] S_TAKE_WB  = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_CMP      = 4'd5;
  localparam logic [3:0] S_SHIFT_RD = 4'd6;
  localparam logic [3:0] S_SHIFT_WR = 4'd7;
  localparam logic [3:0] S_CLEAR    = 4'd8;
  localparam logic [3:0] S_FINISH   = 4'd9;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          case (mode)
            MODE_APPEND: state_next = S_APPEND;
            MODE_TAKE:   state_next = S_TAKE_RD;
            MODE_REMOVE: state_next = S_SCAN;
            MODE_CLEAR:  state_next = S_CLEAR;
            default:     state_next = S_CLEAR;
          endcase
        end
      end
      S_APPEND: begin
        if (stat.full) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_FULL;
        end else begin
          cmd.append = 1'b1;
        end
        state_next = S_FINISH;
      end
      S_TAKE_RD: begin
        if (stat.empty) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_EMPTY;
          state_next = S_FINISH;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_head = 1'b1;
          state_next = S_TAKE_WB;
        end
      end
      S_TAKE_WB: begin
        cmd.take = 1'b1;
        state_next = S_FINISH;
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_NOT_FOUND;
          state_next = S_FINISH;
        end else begin
          cmd.rd_en = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.advance = 1'b1;
        if (stat.match) begin
          cmd.found = 1'b1;
          state_next = S_SHIFT_RD;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SHIFT_RD: begin
        if (stat.scan_end) begin
          cmd.remove = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.rd_en = 1'b1;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.advance = 1'b1;
        state_next = S_SHIFT_RD;
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/pfr_datapath.sv */
// Datapath of the page queue: circular entry store, pointers, count and result words.
module pfr_datapath
  import pfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [PAGE_BITS-1:0]  page,
  output stat_t                 stat,
  output logic [PAGE_BITS-1:0]  page_out,
  output logic [1:0]            status,
  output logic                  is_empty,
  output logic [COUNT_BITS-1:0] entry_count
);

  logic [PAGE_BITS-1:0]  mem [DEPTH];
  logic [PAGE_BITS-1:0]  rd_data;
  logic [ADDR_BITS-1:0]  head;
  logic [COUNT_BITS-1:0] count;
  logic [PAGE_BITS-1:0]  op_page;
  logic [ADDR_BITS-1:0]  scan_ptr;
  logic [ADDR_BITS-1:0]  wr_ptr;
  logic [COUNT_BITS-1:0] idx;
  logic [PAGE_BITS-1:0]  res_page;
  logic [1:0]            res_status;

  logic [SUM_BITS-1:0]   tail_sum;
  logic [ADDR_BITS-1:0]  tail;
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [PAGE_BITS-1:0]  wr_data;
  logic [ADDR_BITS-1:0]  rd_addr;

  assign tail_sum = SUM_BITS'(head) + SUM_BITS'(count);
  assign tail = (tail_sum >= SUM_BITS'(DEPTH)) ? ADDR_BITS'(tail_sum - SUM_BITS'(DEPTH))
                                              : ADDR_BITS'(tail_sum);

  assign wr_en   = cmd.append | cmd.shift_wr;
  assign wr_addr = cmd.append ? tail : wr_ptr;
  assign wr_data = cmd.append ? op_page : rd_data;
  assign rd_addr = cmd.rd_head ? head : scan_ptr;

  assign stat.empty    = (count == '0);
  assign stat.full     = (count == COUNT_BITS'(DEPTH));
  assign stat.scan_end = (idx == count);
  assign stat.match    = (rd_data == op_page);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (cmd.append) begin
        count <= count + 1'b1;
      end else if (cmd.take) begin
        head  <= ptr_inc(head);
        count <= count - 1'b1;
      end else if (cmd.remove) begin
        count <= count - 1'b1;
      end else if (cmd.clear) begin
        head  <= '0;
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_page    <= page;
      scan_ptr   <= head;
      idx        <= '0;
      res_page   <= '0;
      res_status <= ST_DONE;
    end else begin
      if (cmd.advance) begin
        scan_ptr <= ptr_inc(scan_ptr);
        idx      <= idx + 1'b1;
      end
      if (cmd.found || cmd.shift_wr) begin
        wr_ptr <= scan_ptr;
      end
      if (cmd.take) begin
        res_page <= rd_data;
      end
      if (cmd.set_status) begin
        res_status <= cmd.status;
      end
    end
    if (cmd.load_out) begin
      page_out    <= res_page;
      status      <= res_status;
      is_empty    <= (count == '0);
      entry_count <= count;
    end
  end

endmodule

/* rtl/page_fifo_with_removal_unit.sv */
// Top level of the page queue: sequencer and datapath joined by command and status words.
//
// Ordered queue of up to 64 pages held in a circular store with one read and one write
// port. Each accepted word is one operation and yields one result word. Append and clear
// update the queue and then load the result; take reads the head entry and then latches
// it as the result, or reports empty at once. Remove scans from the head, reading and
// comparing one entry at a time, then closes the gap by moving each entry behind the
// match forward one place. A new word is accepted once the previous operation has written
// its result register, even while that result still waits. No clearing pass runs after
// reset.
module page_fifo_with_removal_unit
  import pfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            mode,
  input  logic [PAGE_BITS-1:0]  page,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PAGE_BITS-1:0]  page_out,
  output logic [1:0]            status,
  output logic                  is_empty,
  output logic [COUNT_BITS-1:0] entry_count
);

  cmd_t  cmd;
  stat_t stat;

  pfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfr_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .page        (page),
    .stat        (stat),
    .page_out    (page_out),
    .status      (status),
    .is_empty    (is_empty),
    .entry_count (entry_count)
  );

endmodule

/* rtl/pfr_checker.sv */
// Port-level checks of the page queue and their binding to the top level.
`include "assert_macros.svh"

module pfr_checker
  import pfr_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PAGE_BITS-1:0]  page_out,
  input logic [1:0]            status,
  input logic                  is_empty,
  input logic [COUNT_BITS-1:0] entry_count
);

  localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(DEPTH);

  logic                              out_stall;
  logic [PAGE_BITS+COUNT_BITS+2:0]   out_word;
  logic                              cnt_zero;
  logic                              take_ok;
  logic                              full_ok;

  assign out_stall = out_valid && !out_ready;
  assign out_word  = {page_out, status, is_empty, entry_count};
  assign cnt_zero  = (entry_count == '0);
  assign take_ok   = (status != ST_EMPTY) || (is_empty && page_out == '0);
  assign full_ok   = (status != ST_FULL) || (entry_count == MAX_COUNT);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid && $stable(out_word), "held word changed")
  `ASSERT_ALWAYS(a_empty_flag, clk, rst, !out_valid || (is_empty == cnt_zero), "bad empty flag")
  `ASSERT_ALWAYS(a_count_range, clk, rst, !out_valid || entry_count <= MAX_COUNT, "count too big")
  `ASSERT_ALWAYS(a_take_empty, clk, rst, !out_valid || take_ok, "empty take with data or entries")
  `ASSERT_ALWAYS(a_full_count, clk, rst, !out_valid || full_ok, "full status below depth")

endmodule

bind page_fifo_with_removal_unit pfr_checker u_pfr_checker (.*);
